FILE: design/ppnc_pkg.sv
// ----------------------------------------------------------------------------
// ppnc_pkg
// Shared types, constants and helpers for the portable path name checker.
// ----------------------------------------------------------------------------
package ppnc_pkg;

  // counter width for path and component lengths
  localparam int COUNT_BITS = 16;

  // field widths
  localparam int BYTE_BITS   = 8;
  localparam int PLIM_BITS   = 13;
  localparam int NLIM_BITS   = 12;
  localparam int OLEN_BITS   = 16;
  localparam int VERD_BITS   = 3;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  // reset values of the limits
  localparam logic [PLIM_BITS-1:0] PATH_LIMIT_RST = PLIM_BITS'(256);
  localparam logic [NLIM_BITS-1:0] NAME_LIMIT_RST = NLIM_BITS'(14);

  // reported length saturates here
  localparam logic [31:0] OUT_LEN_MAX = 32'd65535;

  // special characters
  localparam logic [BYTE_BITS-1:0] CHAR_SLASH = 8'h2f;
  localparam logic [BYTE_BITS-1:0] CHAR_DASH  = 8'h2d;
  localparam logic [BYTE_BITS-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [BYTE_BITS-1:0] CHAR_UNDER = 8'h5f;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHECK_PORTABLE = 4'd0,
    REG_CHECK_DASH     = 4'd1,
    REG_PATH_LIMIT     = 4'd2,
    REG_NAME_LIMIT     = 4'd3
  } reg_idx_e;

  // verdict codes
  typedef enum logic [VERD_BITS-1:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_DASH      = 3'd1,
    VERDICT_BAD_CHAR  = 3'd2,
    VERDICT_EMPTY     = 3'd3,
    VERDICT_PATH_LONG = 3'd4,
    VERDICT_COMP_LONG = 3'd5
  } verdict_e;

  typedef struct packed {
    logic                 check_portable_chars;
    logic                 check_leading_dash;
    logic [PLIM_BITS-1:0] path_limit;
    logic [NLIM_BITS-1:0] name_limit;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] name_byte;
    logic                 byte_present;
    logic                 last_byte;
  } item_t;

  typedef struct packed {
    verdict_e             verdict;
    logic [BYTE_BITS-1:0] offending_char;
    logic [OLEN_BITS-1:0] offending_length;
  } res_t;

  // portable set: letters, digits, dot, underscore, dash and slash
  function automatic logic is_portable(input logic [BYTE_BITS-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == CHAR_DOT || c == CHAR_UNDER ||
           c == CHAR_DASH || c == CHAR_SLASH;
  endfunction

  // saturating increment of a length counter
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

FILE: design/ppnc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppnc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ppnc_cfg_regs import ppnc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  // always able to take a write
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_portable_chars <= 1'b0;
      cfg.check_leading_dash   <= 1'b0;
      cfg.path_limit           <= PATH_LIMIT_RST;
      cfg.name_limit           <= NAME_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHECK_PORTABLE: cfg.check_portable_chars <= cfg_data[0];
        REG_CHECK_DASH:     cfg.check_leading_dash   <= cfg_data[0];
        REG_PATH_LIMIT:     cfg.path_limit           <= cfg_data[PLIM_BITS-1:0];
        REG_NAME_LIMIT:     cfg.name_limit           <= cfg_data[NLIM_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/ppnc_in_reg.sv
// ----------------------------------------------------------------------------
// ppnc_in_reg
// Input register stage; holds one word until the scan stage consumes it.
// ----------------------------------------------------------------------------
module ppnc_in_reg import ppnc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic load;
  logic s1_valid_next;

  // take a new word when empty or when the held one moves on
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (load) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_item <= in_item;
    end
  end

endmodule

FILE: design/ppnc_scan.sv
// ----------------------------------------------------------------------------
// ppnc_scan
// Per-name state and verdict logic; updates once per consumed word.
// ----------------------------------------------------------------------------
module ppnc_scan import ppnc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  fire,
  input  item_t item,
  output res_t  res
);

  logic [COUNT_BITS-1:0] path_length, path_length_next;
  logic [COUNT_BITS-1:0] component_length, component_length_next;
  logic                  at_component_start, at_component_start_next;
  logic                  dash_seen, dash_seen_next;
  logic                  bad_char_seen, bad_char_seen_next;
  logic [BYTE_BITS-1:0]  first_bad_char, first_bad_char_next;
  logic                  long_component_seen, long_component_seen_next;
  logic [COUNT_BITS-1:0] first_long_length, first_long_length_next;

  // post-word values before the end-of-name close
  logic [COUNT_BITS-1:0] pl1, cl1, fll1;
  logic                  acs1, ds1, bcs1, lcs1;
  logic [BYTE_BITS-1:0]  fbc1;
  // values after closing the final component
  logic                  lcs2;
  logic [COUNT_BITS-1:0] fll2;
  logic                  basic, extra;
  logic [31:0]           olen_wide;

  // byte update
  always_comb begin
    pl1  = path_length;
    cl1  = component_length;
    acs1 = at_component_start;
    ds1  = dash_seen;
    bcs1 = bad_char_seen;
    fbc1 = first_bad_char;
    lcs1 = long_component_seen;
    fll1 = first_long_length;
    if (item.byte_present) begin
      pl1 = sat_inc(path_length);
      if (!bad_char_seen && !is_portable(item.name_byte)) begin
        bcs1 = 1'b1;
        fbc1 = item.name_byte;
      end
      if (item.name_byte == CHAR_SLASH) begin
        if (!long_component_seen &&
            component_length > COUNT_BITS'(cfg.name_limit)) begin
          lcs1 = 1'b1;
          fll1 = component_length;
        end
        cl1  = '0;
        acs1 = 1'b1;
      end else begin
        if (at_component_start && item.name_byte == CHAR_DASH) begin
          ds1 = 1'b1;
        end
        acs1 = 1'b0;
        cl1  = sat_inc(component_length);
      end
    end
  end

  // close the final component
  always_comb begin
    lcs2 = lcs1;
    fll2 = fll1;
    if (!lcs1 && cl1 > COUNT_BITS'(cfg.name_limit)) begin
      lcs2 = 1'b1;
      fll2 = cl1;
    end
  end

  // verdict in priority order
  always_comb begin
    basic = cfg.check_portable_chars;
    extra = cfg.check_leading_dash;
    res.verdict        = VERDICT_OK;
    res.offending_char = '0;
    olen_wide          = '0;
    priority if (extra && ds1) begin
      res.verdict = VERDICT_DASH;
    end else if (basic && bcs1) begin
      res.verdict        = VERDICT_BAD_CHAR;
      res.offending_char = fbc1;
    end else if ((basic || extra) && pl1 == '0) begin
      res.verdict = VERDICT_EMPTY;
    end else if (basic && pl1 >= COUNT_BITS'(cfg.path_limit)) begin
      res.verdict = VERDICT_PATH_LONG;
      olen_wide   = 32'(pl1);
    end else if (basic && lcs2) begin
      res.verdict = VERDICT_COMP_LONG;
      olen_wide   = 32'(fll2);
    end else begin
      res.verdict = VERDICT_OK;
    end
    res.offending_length = (olen_wide > OUT_LEN_MAX) ? OLEN_BITS'(OUT_LEN_MAX)
                                                     : OLEN_BITS'(olen_wide);
  end

  // next state: clear after the last word of a name
  always_comb begin
    if (item.last_byte) begin
      path_length_next         = '0;
      component_length_next    = '0;
      at_component_start_next  = 1'b1;
      dash_seen_next           = 1'b0;
      bad_char_seen_next       = 1'b0;
      first_bad_char_next      = '0;
      long_component_seen_next = 1'b0;
      first_long_length_next   = '0;
    end else begin
      path_length_next         = pl1;
      component_length_next    = cl1;
      at_component_start_next  = acs1;
      dash_seen_next           = ds1;
      bad_char_seen_next       = bcs1;
      first_bad_char_next      = fbc1;
      long_component_seen_next = lcs1;
      first_long_length_next   = fll1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      path_length         <= '0;
      component_length    <= '0;
      at_component_start  <= 1'b1;
      dash_seen           <= 1'b0;
      bad_char_seen       <= 1'b0;
      first_bad_char      <= '0;
      long_component_seen <= 1'b0;
      first_long_length   <= '0;
    end else if (fire) begin
      path_length         <= path_length_next;
      component_length    <= component_length_next;
      at_component_start  <= at_component_start_next;
      dash_seen           <= dash_seen_next;
      bad_char_seen       <= bad_char_seen_next;
      first_bad_char      <= first_bad_char_next;
      long_component_seen <= long_component_seen_next;
      first_long_length   <= first_long_length_next;
    end
  end

  // a finished name leaves the state clear
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && item.last_byte |=> path_length == '0 && at_component_start &&
                               !bad_char_seen && !long_component_seen)
    else $error("name state not cleared after last word");

  // path length only grows within a name
  a_path_grows: assert property (@(posedge clk) disable iff (rst)
    !(fire && item.last_byte) |=> path_length >= $past(path_length))
    else $error("path length went down inside a name");

  // component never longer than the path
  a_comp_le_path: assert property (@(posedge clk) disable iff (rst)
    component_length <= path_length)
    else $error("component longer than path");

  // offending char only with a bad character verdict
  a_char_only_bad: assert property (@(posedge clk) disable iff (rst)
    res.verdict != VERDICT_BAD_CHAR |-> res.offending_char == '0)
    else $error("offending char set for wrong verdict");

endmodule

FILE: design/ppnc_out_reg.sv
// ----------------------------------------------------------------------------
// ppnc_out_reg
// Result register; holds a word until the sink takes it.
// ----------------------------------------------------------------------------
module ppnc_out_reg import ppnc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  res_t                 res,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERD_BITS-1:0] verdict,
  output logic [BYTE_BITS-1:0] offending_char,
  output logic [OLEN_BITS-1:0] offending_length
);

  logic load;

  // free when empty or when the held word leaves this cycle
  assign can_take = !out_valid || !out_stall;
  assign load     = res_valid && can_take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      verdict          <= res.verdict;
      offending_char   <= res.offending_char;
      offending_length <= res.offending_length;
    end
  end

endmodule

FILE: design/portable_path_name_checker_top.sv
// Path: an accepted word is held in the input register; the verdict for a last word is
//   captured in the result register once that register has room.
// Throughput: one word per cycle unless stalled; one scan stage updates all per-name state.
// Reset: rst clears the pipeline valids and per-name state and loads the register defaults
//   (both checks off, path limit 256, name limit 14).
// ----------------------------------------------------------------------------
// portable_path_name_checker_top
// Checks a byte-serial file name for portability and reports one verdict.
// ----------------------------------------------------------------------------
module portable_path_name_checker_top import ppnc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_BITS-1:0]     name_byte,
  input  logic                     byte_present,
  input  logic                     last_byte,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VERD_BITS-1:0]     verdict,
  output logic [BYTE_BITS-1:0]     offending_char,
  output logic [OLEN_BITS-1:0]     offending_length
);

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  advance;
  logic  can_take;
  logic  fire;
  res_t  res;

  assign in_item.name_byte    = name_byte;
  assign in_item.byte_present = byte_present;
  assign in_item.last_byte    = last_byte;

  // a last word needs room in the result register
  assign advance = !s1_item.last_byte || can_take;
  assign fire    = s1_valid && advance;

  ppnc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppnc_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ppnc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (s1_item),
    .res  (res)
  );

  ppnc_out_reg u_out (
    .clk              (clk),
    .rst              (rst),
    .res_valid        (s1_valid && s1_item.last_byte),
    .res              (res),
    .can_take         (can_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .verdict          (verdict),
    .offending_char   (offending_char),
    .offending_length (offending_length)
  );

endmodule
